@@ hdl/fps_cam_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants and the arctangent table of the camera core.
package fps_cam_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;

    // Rotation datapath width and iteration cap
    localparam int ANG_W    = 34;
    localparam int MAX_ITER = 24;

    localparam logic signed [ANG_W-1:0]  CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [MUL_W-1:0]  PI_Q30      = 33'sd3373259426;
    localparam logic signed [15:0]       PITCH_MIN   = -16'sd16466;
    localparam logic signed [15:0]       PITCH_MAX   = 16'sd16302;
    localparam logic signed [15:0]       ONE_Q14     = 16'sd16384;
    localparam logic signed [31:0]       ONE_Q16     = 32'sd65536;
    localparam logic [15:0]              SENS_RESET  = 16'd256;
    localparam logic signed [PROD_W-1:0] SAT_HI      = 66'sh0_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_LO      = -66'sh0_8000_0000;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        begin
            unique case (i)
                5'd0:  v = 30'h3243F6A8;
                5'd1:  v = 30'h1DAC6705;
                5'd2:  v = 30'h0FADBAFC;
                5'd3:  v = 30'h07F56EA6;
                5'd4:  v = 30'h03FEAB76;
                5'd5:  v = 30'h01FFD55B;
                5'd6:  v = 30'h00FFFAAA;
                5'd7:  v = 30'h007FFF55;
                5'd8:  v = 30'h003FFFEA;
                5'd9:  v = 30'h001FFFFD;
                5'd10: v = 30'h000FFFFF;
                5'd11: v = 30'h0007FFFF;
                5'd12: v = 30'h0003FFFF;
                5'd13: v = 30'h0001FFFF;
                5'd14: v = 30'h0000FFFF;
                5'd15: v = 30'h00007FFF;
                5'd16: v = 30'h00003FFF;
                5'd17: v = 30'h00001FFF;
                5'd18: v = 30'h00000FFF;
                5'd19: v = 30'h000007FF;
                5'd20: v = 30'h000003FF;
                5'd21: v = 30'h000001FF;
                5'd22: v = 30'h000000FF;
                5'd23: v = 30'h0000007F;
                default: v = 30'h0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/fps_cam_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
module fps_cam_mul (
    input  logic                                    clk,
    input  logic signed [fps_cam_pkg::MUL_W-1:0]   a,
    input  logic signed [fps_cam_pkg::MUL_W-1:0]   b,
    output logic signed [fps_cam_pkg::PROD_W-1:0]  p
);

    logic signed [fps_cam_pkg::PROD_W-1:0] p_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        p_reg <= fps_cam_pkg::PROD_W'(a) * fps_cam_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

@@ hdl/fps_cam_sqrt.sv @@
`timescale 1ns / 1ps
// Bit-serial integer square root of a 64-bit value, two result bits per step pair.
module fps_cam_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    // Step one result bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                v_reg   <= val;
                res_reg <= 64'd0;
                bit_reg <= 64'h4000_0000_0000_0000;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

@@ hdl/fps_cam_div.sv @@
`timescale 1ns / 1ps
// Restoring divider giving a 16-bit quotient, one bit per cycle.
module fps_cam_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quot
);

    logic [47:0] rem_reg;
    logic [47:0] dsh_reg;
    logic [15:0] q_reg;
    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    // Subtract the shifted divisor where it fits, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= num;
                dsh_reg <= 48'({den, 15'd0});
                q_reg   <= 16'd0;
                cnt_reg <= 4'd0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[14:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[14:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ hdl/fps_cam_cordic.sv @@
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC giving cosine and sine in Q30.
module fps_cam_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [fps_cam_pkg::ANG_W-1:0]  z_in,
    output logic                                   done,
    output logic signed [fps_cam_pkg::ANG_W-1:0]  cos_out,
    output logic signed [fps_cam_pkg::ANG_W-1:0]  sin_out
);

    localparam int ITER = (ITERATIONS < fps_cam_pkg::MAX_ITER) ? ITERATIONS
                                                               : fps_cam_pkg::MAX_ITER;
    localparam int CW   = $clog2(fps_cam_pkg::MAX_ITER);

    logic signed [fps_cam_pkg::ANG_W-1:0] x_reg;
    logic signed [fps_cam_pkg::ANG_W-1:0] y_reg;
    logic signed [fps_cam_pkg::ANG_W-1:0] z_reg;
    logic [CW-1:0]                        cnt_reg;
    logic                                 run_reg;
    logic                                 done_reg;
    logic signed [fps_cam_pkg::ANG_W-1:0] xs;
    logic signed [fps_cam_pkg::ANG_W-1:0] ys;
    logic signed [fps_cam_pkg::ANG_W-1:0] at;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = fps_cam_pkg::ANG_W'(fps_cam_pkg::atan_q30(5'(cnt_reg)));

    // Rotate toward zero residual angle, one micro-rotation a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg   <= fps_cam_pkg::CORDIC_GAIN;
                y_reg   <= '0;
                z_reg   <= z_in;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ITER - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

@@ hdl/fps_camera_view_matrix_core.sv @@
`timescale 1ns / 1ps
// First-person camera core: per-frame pose update and 4x4 view matrix output.
//
// Input channel (in_valid / in_stall): one beat per frame carries the mouse
// deltas, the frame time and six move flags. in_stall is high from the
// accepting edge until the last matrix row has been taken.
// Output channel (out_valid / out_stall): four beats per frame, rows 0 to 3,
// last_row marks row 3. A stalled row holds until it is taken.
// Configuration: cfg_write loads cfg_data into the mouse sensitivity at once;
// write it only while the core is idle.
// Processing: vector normalizations dominate; two per frame, three with
// mouse motion. Each forms the sum of squares, takes its root in the shared
// square-root unit and divides each component in the divider. Mouse motion
// also adds two CORDIC runs, and a move flag that gives a nonzero velocity
// adds the position update.
// Flow: one frame at a time; after the four output beats the core returns
// to idle, which takes the next beat.
// Reset: pose returns to origin looking down +Z, sensitivity to 1.0 (Q8.8).
// Downstream stall only stretches the output phase; nothing is lost.
module fps_camera_view_matrix_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [11:0] mouse_dx,
    input  logic signed [11:0] mouse_dy,
    input  logic [15:0]        frame_time,
    input  logic               move_right,
    input  logic               move_left,
    input  logic               move_forward,
    input  logic               move_backward,
    input  logic               move_up,
    input  logic               move_down,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         row_index,
    output logic signed [31:0] entry0,
    output logic signed [31:0] entry1,
    output logic signed [31:0] entry2,
    output logic signed [31:0] entry3,
    output logic               last_row
);

    localparam int MW = fps_cam_pkg::MUL_W;
    localparam int PW = fps_cam_pkg::PROD_W;
    localparam int AW = fps_cam_pkg::ANG_W;

    typedef enum logic [4:0] {
        S_IDLE, S_VEL, S_POS_M, S_POS_A, S_ANG_CHK, S_ANG_M1, S_ANG_M2, S_ANG_A,
        S_SC_SEL, S_SC_M, S_SC_Z, S_SC_W, S_FWD_M0, S_FWD_M1, S_FWD_A, S_RGT,
        S_UP_M, S_UP_A, S_N_SQ_M, S_N_SQ_A, S_N_SQRT, S_N_SQRT_W, S_N_DIV,
        S_N_DIV_W, S_DOT_M, S_DOT_A, S_OUT
    } state_t;

    typedef enum logic [1:0] {DST_FWD, DST_RGT, DST_UP} dst_t;

    state_t                state_reg;
    dst_t                  dst_reg;
    logic [3:0]            k_reg;
    logic [1:0]            row_reg;
    logic [15:0]           sens_reg;
    logic [15:0]           yaw_reg;
    logic signed [15:0]    pit_reg;
    logic signed [15:0]    fwd_reg [3];
    logic signed [15:0]    rgt_reg [3];
    logic signed [15:0]    upa_reg [3];
    logic signed [31:0]    pos_reg [3];
    logic signed [31:0]    trans_reg [3];
    logic signed [18:0]    vel_reg [3];
    logic signed [MW-1:0]  vec_reg [3];
    logic signed [PW-1:0]  acc_reg;
    logic [31:0]           len_reg;
    logic signed [16:0]    ang_reg;
    logic                  flip_reg;
    logic signed [MW-1:0]  cp_reg;
    logic signed [MW-1:0]  sp_reg;
    logic signed [MW-1:0]  cy_reg;
    logic signed [MW-1:0]  sy_reg;
    logic signed [11:0]    dx_reg;
    logic signed [11:0]    dy_reg;
    logic [15:0]           t_reg;
    logic [5:0]            flags_reg;

    logic [1:0]            k2;
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic signed [18:0]    vel_calc [3];
    logic signed [31:0]    pos_new;
    logic signed [PW-1:0]  ang_delta;
    logic signed [PW-1:0]  pit_wide;
    logic signed [15:0]    pit_new;
    logic signed [16:0]    ang_raw;
    logic signed [16:0]    ang_adj;
    logic                  flip_calc;
    logic signed [16:0]    ang_abs;
    logic signed [PW-1:0]  z_mag;
    logic signed [AW-1:0]  z_val;
    logic signed [MW-1:0]  rnd30;
    logic [MW-1:0]         vec_abs;
    logic [47:0]           div_num;
    logic [15:0]           q_sat;
    logic signed [15:0]    q_signed;
    logic signed [PW-1:0]  sq_sum;
    logic [1:0]            dot_i;
    logic [1:0]            dot_j;
    logic                  dot_first;
    logic signed [PW-1:0]  dot_sum;
    logic signed [31:0]    trans_new;

    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [31:0]           sqrt_root;
    logic                  div_start;
    logic                  div_done;
    logic [15:0]           div_q;
    logic                  cor_start;
    logic                  cor_done;
    logic signed [AW-1:0]  cor_cos;
    logic signed [AW-1:0]  cor_sin;

    function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                    input int n);
        logic signed [PW-1:0] half;
        begin
            half = PW'(1) <<< (n - 1);
            return (v + half) >>> n;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        begin
            if (v > fps_cam_pkg::SAT_HI)
                return 32'sh7FFF_FFFF;
            else if (v < fps_cam_pkg::SAT_LO)
                return -32'sh8000_0000;
            else
                return v[31:0];
        end
    endfunction

    function automatic logic signed [18:0] vterm(input logic p, input logic n,
                                                 input logic signed [15:0] x);
        begin
            if (p && !n)
                return 19'(x);
            else if (!p && n)
                return -19'(x);
            else
                return 19'sd0;
        end
    endfunction

    function automatic logic signed [31:0] axis_entry(input logic signed [15:0] x);
        begin
            return {{14{x[15]}}, x, 2'b00};
        end
    endfunction

    assign k2 = k_reg[1:0];

    // Shared arithmetic units
    fps_cam_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    fps_cam_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   (acc_reg[63:0]),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    fps_cam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    fps_cam_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .z_in    (z_val),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign sqrt_start = (state_reg == S_N_SQRT);
    assign div_start  = (state_reg == S_N_DIV) && (len_reg != 32'd0);
    assign cor_start  = (state_reg == S_SC_Z);

    // Split the dot-product step into axis and component
    always_comb
    begin
        priority if (k_reg < 4'd3)
        begin
            dot_j = 2'd0;
            dot_i = k_reg[1:0];
        end
        else if (k_reg < 4'd6)
        begin
            dot_j = 2'd1;
            dot_i = 2'(k_reg - 4'd3);
        end
        else
        begin
            dot_j = 2'd2;
            dot_i = 2'(k_reg - 4'd6);
        end
        dot_first = (dot_i == 2'd0);
    end

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_POS_M:
            begin
                mul_a = MW'(vel_reg[k2]);
                mul_b = MW'(t_reg);
            end
            S_ANG_M1:
            begin
                mul_a = k_reg[0] ? MW'(dy_reg) : MW'(dx_reg);
                mul_b = MW'(sens_reg);
            end
            S_ANG_M2:
            begin
                mul_a = prod[MW-1:0];
                mul_b = MW'(t_reg);
            end
            S_SC_M:
            begin
                mul_a = MW'(ang_abs);
                mul_b = fps_cam_pkg::PI_Q30;
            end
            S_FWD_M0:
            begin
                mul_a = cp_reg;
                mul_b = sy_reg;
            end
            S_FWD_M1:
            begin
                mul_a = cp_reg;
                mul_b = cy_reg;
            end
            S_N_SQ_M:
            begin
                mul_a = vec_reg[k2];
                mul_b = vec_reg[k2];
            end
            S_UP_M:
            begin
                unique case (k_reg)
                    4'd0: begin mul_a = MW'(fwd_reg[1]); mul_b = MW'(rgt_reg[2]); end
                    4'd1: begin mul_a = MW'(fwd_reg[2]); mul_b = MW'(rgt_reg[1]); end
                    4'd2: begin mul_a = MW'(fwd_reg[2]); mul_b = MW'(rgt_reg[0]); end
                    4'd3: begin mul_a = MW'(fwd_reg[0]); mul_b = MW'(rgt_reg[2]); end
                    4'd4: begin mul_a = MW'(fwd_reg[0]); mul_b = MW'(rgt_reg[1]); end
                    4'd5: begin mul_a = MW'(fwd_reg[1]); mul_b = MW'(rgt_reg[0]); end
                    default: ;
                endcase
            end
            S_DOT_M:
            begin
                mul_a = MW'(pos_reg[dot_i]);
                unique case (dot_j)
                    2'd0:    mul_b = MW'(rgt_reg[dot_i]);
                    2'd1:    mul_b = MW'(upa_reg[dot_i]);
                    default: mul_b = MW'(fwd_reg[dot_i]);
                endcase
            end
            default: ;
        endcase
    end

    // Datapath helpers around the shared product
    always_comb
    begin
        vel_calc[0] = vterm(flags_reg[0], flags_reg[1], rgt_reg[0])
                    + vterm(flags_reg[2], flags_reg[3], fwd_reg[0]);
        vel_calc[1] = vterm(flags_reg[0], flags_reg[1], rgt_reg[1])
                    + vterm(flags_reg[2], flags_reg[3], fwd_reg[1])
                    + vterm(flags_reg[4], flags_reg[5], fps_cam_pkg::ONE_Q14);
        vel_calc[2] = vterm(flags_reg[0], flags_reg[1], rgt_reg[2])
                    + vterm(flags_reg[2], flags_reg[3], fwd_reg[2]);

        pos_new   = sat32(PW'(pos_reg[k2]) + rnd_sh(prod, 14));

        ang_delta = rnd_sh(prod, 24);
        pit_wide  = PW'(pit_reg) - ang_delta;
        if (pit_wide < PW'(fps_cam_pkg::PITCH_MIN))
            pit_new = fps_cam_pkg::PITCH_MIN;
        else if (pit_wide > PW'(fps_cam_pkg::PITCH_MAX))
            pit_new = fps_cam_pkg::PITCH_MAX;
        else
            pit_new = pit_wide[15:0];

        ang_raw = k_reg[0] ? 17'($signed(yaw_reg)) : 17'(pit_reg);
        if (ang_raw > 17'sd16384)
        begin
            ang_adj   = ang_raw - 17'sd32768;
            flip_calc = 1'b1;
        end
        else if (ang_raw < -17'sd16384)
        begin
            ang_adj   = ang_raw + 17'sd32768;
            flip_calc = 1'b1;
        end
        else
        begin
            ang_adj   = ang_raw;
            flip_calc = 1'b0;
        end
        ang_abs = (ang_reg < 0) ? -ang_reg : ang_reg;

        z_mag = (prod + PW'(16384)) >>> 15;
        z_val = (ang_reg < 0) ? -AW'(z_mag) : AW'(z_mag);

        rnd30 = MW'(rnd_sh(prod, 30));

        vec_abs  = (vec_reg[k2] < 0) ? MW'(-vec_reg[k2]) : MW'(vec_reg[k2]);
        div_num  = 48'({vec_abs, 14'd0}) + 48'(len_reg >> 1);
        q_sat    = (div_q > 16'd32767) ? 16'd32767 : div_q;
        q_signed = (vec_reg[k2] < 0) ? -$signed(q_sat) : $signed(q_sat);

        sq_sum    = ((k_reg == 4'd0) ? PW'(0) : acc_reg) + prod;
        dot_sum   = (dot_first ? PW'(0) : acc_reg) + prod;
        trans_new = sat32(-rnd_sh(dot_sum, 14));
    end

    // Sequencer: hold state, pose and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dst_reg   <= DST_FWD;
            k_reg     <= 4'd0;
            row_reg   <= 2'd0;
            sens_reg  <= fps_cam_pkg::SENS_RESET;
            yaw_reg   <= 16'd0;
            pit_reg   <= 16'sd0;
            for (int i = 0; i < 3; i++)
            begin
                fwd_reg[i] <= 16'sd0;
                rgt_reg[i] <= 16'sd0;
                upa_reg[i] <= 16'sd0;
                pos_reg[i] <= 32'sd0;
            end
            fwd_reg[2] <= fps_cam_pkg::ONE_Q14;
            rgt_reg[0] <= fps_cam_pkg::ONE_Q14;
            upa_reg[1] <= fps_cam_pkg::ONE_Q14;
        end
        else
        begin
            if (cfg_write)
                sens_reg <= cfg_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dx_reg    <= mouse_dx;
                        dy_reg    <= mouse_dy;
                        t_reg     <= frame_time;
                        flags_reg <= {move_down, move_up, move_backward, move_forward,
                                      move_left, move_right};
                        state_reg <= S_VEL;
                    end
                end
                // Sum the flagged axes; move only when the sum is nonzero
                S_VEL:
                begin
                    for (int i = 0; i < 3; i++)
                        vel_reg[i] <= vel_calc[i];
                    k_reg <= 4'd0;
                    if (vel_calc[0] != 0 || vel_calc[1] != 0 || vel_calc[2] != 0)
                        state_reg <= S_POS_M;
                    else
                        state_reg <= S_ANG_CHK;
                end
                S_POS_M:
                    state_reg <= S_POS_A;
                S_POS_A:
                begin
                    pos_reg[k2] <= pos_new;
                    if (k_reg == 4'd2)
                    begin
                        k_reg     <= 4'd0;
                        state_reg <= S_ANG_CHK;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_POS_M;
                    end
                end
                S_ANG_CHK:
                begin
                    k_reg <= 4'd0;
                    if (dx_reg != 0 || dy_reg != 0)
                        state_reg <= S_ANG_M1;
                    else
                        state_reg <= S_RGT;
                end
                S_ANG_M1:
                    state_reg <= S_ANG_M2;
                S_ANG_M2:
                    state_reg <= S_ANG_A;
                // Wrap yaw, clamp pitch
                S_ANG_A:
                begin
                    if (k_reg[0])
                    begin
                        pit_reg   <= pit_new;
                        k_reg     <= 4'd0;
                        state_reg <= S_SC_SEL;
                    end
                    else
                    begin
                        yaw_reg   <= yaw_reg + ang_delta[15:0];
                        k_reg     <= 4'd1;
                        state_reg <= S_ANG_M1;
                    end
                end
                // Fold the angle into the half-turn around zero
                S_SC_SEL:
                begin
                    ang_reg   <= ang_adj;
                    flip_reg  <= flip_calc;
                    state_reg <= S_SC_M;
                end
                S_SC_M:
                    state_reg <= S_SC_Z;
                S_SC_Z:
                    state_reg <= S_SC_W;
                S_SC_W:
                begin
                    if (cor_done)
                    begin
                        if (k_reg[0])
                        begin
                            cy_reg    <= flip_reg ? -cor_cos[MW-1:0] : cor_cos[MW-1:0];
                            sy_reg    <= flip_reg ? -cor_sin[MW-1:0] : cor_sin[MW-1:0];
                            k_reg     <= 4'd0;
                            state_reg <= S_FWD_M0;
                        end
                        else
                        begin
                            cp_reg    <= flip_reg ? -cor_cos[MW-1:0] : cor_cos[MW-1:0];
                            sp_reg    <= flip_reg ? -cor_sin[MW-1:0] : cor_sin[MW-1:0];
                            k_reg     <= 4'd1;
                            state_reg <= S_SC_SEL;
                        end
                    end
                end
                S_FWD_M0:
                    state_reg <= S_FWD_M1;
                S_FWD_M1:
                begin
                    vec_reg[0] <= rnd30;
                    state_reg  <= S_FWD_A;
                end
                S_FWD_A:
                begin
                    vec_reg[1] <= sp_reg;
                    vec_reg[2] <= rnd30;
                    dst_reg    <= DST_FWD;
                    k_reg      <= 4'd0;
                    state_reg  <= S_N_SQ_M;
                end
                // Right axis from world up crossed with forward
                S_RGT:
                begin
                    vec_reg[0] <= MW'(fwd_reg[2]);
                    vec_reg[1] <= '0;
                    vec_reg[2] <= -MW'(fwd_reg[0]);
                    dst_reg    <= DST_RGT;
                    k_reg      <= 4'd0;
                    state_reg  <= S_N_SQ_M;
                end
                S_UP_M:
                    state_reg <= S_UP_A;
                // Cross product forward x right, two products per component
                S_UP_A:
                begin
                    if (!k_reg[0])
                        acc_reg <= prod;
                    else
                        vec_reg[k_reg[2:1]] <= MW'(acc_reg - prod);
                    if (k_reg == 4'd5)
                    begin
                        dst_reg   <= DST_UP;
                        k_reg     <= 4'd0;
                        state_reg <= S_N_SQ_M;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_UP_M;
                    end
                end
                // Normalize: sum of squares, root, then one divide per component
                S_N_SQ_M:
                    state_reg <= S_N_SQ_A;
                S_N_SQ_A:
                begin
                    acc_reg <= sq_sum;
                    if (k_reg == 4'd2)
                        state_reg <= S_N_SQRT;
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_N_SQ_M;
                    end
                end
                S_N_SQRT:
                    state_reg <= S_N_SQRT_W;
                S_N_SQRT_W:
                begin
                    if (sqrt_done)
                    begin
                        len_reg   <= sqrt_root;
                        k_reg     <= 4'd0;
                        state_reg <= S_N_DIV;
                    end
                end
                S_N_DIV:
                    state_reg <= S_N_DIV_W;
                S_N_DIV_W:
                begin
                    if (div_done || len_reg == 32'd0)
                    begin
                        unique case (dst_reg)
                            DST_FWD: fwd_reg[k2] <= (len_reg == 32'd0) ? 16'sd0 : q_signed;
                            DST_RGT: rgt_reg[k2] <= (len_reg == 32'd0) ? 16'sd0 : q_signed;
                            DST_UP:  upa_reg[k2] <= (len_reg == 32'd0) ? 16'sd0 : q_signed;
                            default: ;
                        endcase
                        if (k_reg == 4'd2)
                        begin
                            k_reg <= 4'd0;
                            unique case (dst_reg)
                                DST_FWD: state_reg <= S_RGT;
                                DST_RGT: state_reg <= S_UP_M;
                                default: state_reg <= S_DOT_M;
                            endcase
                        end
                        else
                        begin
                            k_reg     <= k_reg + 4'd1;
                            state_reg <= S_N_DIV;
                        end
                    end
                end
                S_DOT_M:
                    state_reg <= S_DOT_A;
                // Accumulate position against each axis for the translation row
                S_DOT_A:
                begin
                    acc_reg <= dot_sum;
                    if (dot_i == 2'd2)
                        trans_reg[dot_j] <= trans_new;
                    if (k_reg == 4'd8)
                    begin
                        k_reg     <= 4'd0;
                        row_reg   <= 2'd0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_DOT_M;
                    end
                end
                // Hand out one row per beat
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (row_reg == 2'd3)
                            state_reg <= S_IDLE;
                        else
                            row_reg <= row_reg + 2'd1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign row_index = row_reg;
    assign last_row  = (row_reg == 2'd3);

    // Build the current row from the held axes and translation
    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                entry0 = axis_entry(rgt_reg[0]);
                entry1 = axis_entry(upa_reg[0]);
                entry2 = axis_entry(fwd_reg[0]);
                entry3 = 32'sd0;
            end
            2'd1:
            begin
                entry0 = axis_entry(rgt_reg[1]);
                entry1 = axis_entry(upa_reg[1]);
                entry2 = axis_entry(fwd_reg[1]);
                entry3 = 32'sd0;
            end
            2'd2:
            begin
                entry0 = axis_entry(rgt_reg[2]);
                entry1 = axis_entry(upa_reg[2]);
                entry2 = axis_entry(fwd_reg[2]);
                entry3 = 32'sd0;
            end
            default:
            begin
                entry0 = trans_reg[0];
                entry1 = trans_reg[1];
                entry2 = trans_reg[2];
                entry3 = fps_cam_pkg::ONE_Q16;
            end
        endcase
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the first-person camera view matrix core.
module tb_top;

    localparam int  CAM_ITERS  = 16;
    localparam int  HALF_CLK   = 6;
    localparam int  MAX_CYCLES = 4000000;
    localparam int  DRAIN_WAIT = 500;
    localparam int  HOLD_LEN   = 1500;
    localparam int  N_ITEMS    = 370;

    localparam longint ONE_Q14_V = 16384;
    localparam longint GAIN_Q30  = 652032874;
    localparam longint PI_Q30_V  = 64'sd3373259426;
    localparam longint PIT_LO    = -16466;
    localparam longint PIT_HI    = 16302;

    // Arctangent steps in Q30
    localparam longint ATAN_STEP [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    typedef struct packed {
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic [15:0]        ft;
        logic [5:0]         flags;   // right, left, fwd, back, up, down
    } frame_beat_t;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] e0;
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic signed [31:0] e3;
        logic               last;
    } matrix_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [11:0] mouse_dx = '0;
    logic signed [11:0] mouse_dy = '0;
    logic [15:0]        frame_time = '0;
    logic               move_right = 1'b0;
    logic               move_left = 1'b0;
    logic               move_forward = 1'b0;
    logic               move_backward = 1'b0;
    logic               move_up = 1'b0;
    logic               move_down = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         row_index;
    logic signed [31:0] entry0, entry1, entry2, entry3;
    logic               last_row;

    frame_beat_t  pending_frames [$];
    matrix_row_t  expected_rows [$];
    frame_beat_t  cur_frame;
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           hold_left = 0;
    logic         hold_go = 1'b0;
    logic         no_idle = 1'b0;

    // Camera pose as tracked by the testbench
    logic [15:0]  cam_sens = 16'd256;
    logic [15:0]  cam_yaw = '0;
    longint       cam_pitch = 0;
    longint       cam_fwd [3] = '{0, 0, ONE_Q14_V};
    longint       cam_right [3] = '{ONE_Q14_V, 0, 0};
    longint       cam_up [3] = '{0, ONE_Q14_V, 0};
    longint       cam_pos [3] = '{0, 0, 0};

    fps_camera_view_matrix_core #(.CORDIC_ITERATIONS(CAM_ITERS)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mouse_dx(mouse_dx), .mouse_dy(mouse_dy), .frame_time(frame_time),
        .move_right(move_right), .move_left(move_left),
        .move_forward(move_forward), .move_backward(move_backward),
        .move_up(move_up), .move_down(move_down),
        .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
        .entry0(entry0), .entry1(entry1), .entry2(entry2), .entry3(entry3),
        .last_row(last_row)
    );

    always #(HALF_CLK) clk = ~clk;

    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale a vector to unit length in Q2.14; zero stays zero
    task automatic unit_vec(input longint c [3], output longint r [3]);
        logic [63:0] mag [3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = (c[k] < 0) ? -c[k] : c[k];
            sum = sum + mag[k] * mag[k];
        end
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++)
        begin
            if (len == 0)
                r[k] = 0;
            else
            begin
                q = ((mag[k] << 14) + len / 2) / len;
                if (q > 32767) q = 32767;
                r[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endtask

    // Rotate the gain vector by a binary angle
    task automatic angle_cos_sin(input longint a, output longint c, output longint s);
        logic   flip;
        longint x, y, z, mag, xs, ys;
        flip = 1'b0;
        x = GAIN_Q30;
        y = 0;
        if (a > 16384)
        begin
            a = a - 32768;
            flip = 1'b1;
        end
        else if (a < -16384)
        begin
            a = a + 32768;
            flip = 1'b1;
        end
        mag = ((a < 0) ? -a : a) * PI_Q30_V;
        mag = (mag + 16384) >>> 15;
        z = (a < 0) ? -mag : mag;
        for (int i = 0; i < CAM_ITERS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the pose by one frame and queue the four matrix rows
    task automatic advance_camera(input frame_beat_t f);
        longint dx, dy, t, sr, sf, su, dyaw, dpit, p, cp, sp, cy, sy;
        longint vel [3];
        longint tmp [3];
        longint dr, du, df;
        matrix_row_t row;
        dx = longint'(f.dx);
        dy = longint'(f.dy);
        t = longint'(f.ft);
        sr = longint'(f.flags[5]) - longint'(f.flags[4]);
        sf = longint'(f.flags[3]) - longint'(f.flags[2]);
        su = longint'(f.flags[1]) - longint'(f.flags[0]);
        for (int k = 0; k < 3; k++)
            vel[k] = sr * cam_right[k] + sf * cam_fwd[k] + ((k == 1) ? su * ONE_Q14_V : 0);
        if (vel[0] != 0 || vel[1] != 0 || vel[2] != 0)
            for (int k = 0; k < 3; k++)
                cam_pos[k] = clip32(cam_pos[k] + round_shift(vel[k] * t, 14));

        if (dx != 0 || dy != 0)
        begin
            dyaw = round_shift(dx * longint'(cam_sens) * t, 24);
            dpit = round_shift(dy * longint'(cam_sens) * t, 24);
            cam_yaw = cam_yaw + dyaw[15:0];
            p = cam_pitch - dpit;
            if (p < PIT_LO) p = PIT_LO;
            if (p > PIT_HI) p = PIT_HI;
            cam_pitch = p;
            angle_cos_sin(p, cp, sp);
            angle_cos_sin(longint'($signed(cam_yaw)), cy, sy);
            tmp[0] = round_shift(cp * sy, 30);
            tmp[1] = sp;
            tmp[2] = round_shift(cp * cy, 30);
            unit_vec(tmp, cam_fwd);
        end

        tmp[0] = cam_fwd[2];
        tmp[1] = 0;
        tmp[2] = -cam_fwd[0];
        unit_vec(tmp, cam_right);
        tmp[0] = cam_fwd[1] * cam_right[2] - cam_fwd[2] * cam_right[1];
        tmp[1] = cam_fwd[2] * cam_right[0] - cam_fwd[0] * cam_right[2];
        tmp[2] = cam_fwd[0] * cam_right[1] - cam_fwd[1] * cam_right[0];
        unit_vec(tmp, cam_up);

        for (int k = 0; k < 3; k++)
        begin
            row.row = k[1:0];
            row.e0 = 32'(cam_right[k] * 4);
            row.e1 = 32'(cam_up[k] * 4);
            row.e2 = 32'(cam_fwd[k] * 4);
            row.e3 = '0;
            row.last = 1'b0;
            expected_rows.push_back(row);
        end
        dr = 0;
        du = 0;
        df = 0;
        for (int k = 0; k < 3; k++)
        begin
            dr = dr + cam_pos[k] * cam_right[k];
            du = du + cam_pos[k] * cam_up[k];
            df = df + cam_pos[k] * cam_fwd[k];
        end
        row.row = 2'd3;
        row.e0 = 32'(clip32(-round_shift(dr, 14)));
        row.e1 = 32'(clip32(-round_shift(du, 14)));
        row.e2 = 32'(clip32(-round_shift(df, 14)));
        row.e3 = 32'sd65536;
        row.last = 1'b1;
        expected_rows.push_back(row);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    // Input side: hold a stalled beat, advance on accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                advance_camera(cur_frame);
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_frames.size() > 0)
                begin
                    cur_frame = pending_frames.pop_front();
                    mouse_dx <= cur_frame.dx;
                    mouse_dy <= cur_frame.dy;
                    frame_time <= cur_frame.ft;
                    {move_right, move_left, move_forward, move_backward, move_up, move_down}
                        <= cur_frame.flags;
                    in_valid <= 1'b1;
                    send_gap <= no_idle ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_go && hold_left == 0)
            hold_left <= HOLD_LEN;
        else if (hold_left > 1)
            hold_left <= hold_left - 1;
    end

    // Output side: check each row beat, then pick the next stall
    always @(posedge clk)
    begin
        matrix_row_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rows.size() == 0)
                    report("unexpected row", row_index, -1);
                else
                begin
                    want = expected_rows.pop_front();
                    if (row_index !== want.row) report("row_index", row_index, want.row);
                    if (entry0 !== want.e0) report("entry0", entry0, want.e0);
                    if (entry1 !== want.e1) report("entry1", entry1, want.e1);
                    if (entry2 !== want.e2) report("entry2", entry2, want.e2);
                    if (entry3 !== want.e3) report("entry3", entry3, want.e3);
                    if (last_row !== want.last) report("last_row", last_row, want.last);
                end
            end
            if (hold_left > 1 || (hold_go && hold_left == 0))
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                recv_gap <= no_idle ? 0 : pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic frame_beat_t make_frame(int dx, int dy, int ft, logic [5:0] fl);
        frame_beat_t f;
        f.dx = dx[11:0];
        f.dy = dy[11:0];
        f.ft = ft[15:0];
        f.flags = fl;
        return f;
    endfunction

    // Mostly plausible frames, some pure noise
    function automatic frame_beat_t random_frame();
        frame_beat_t f;
        if ($urandom_range(0, 9) == 0)
        begin
            f = frame_beat_t'({$urandom, $urandom});
            return f;
        end
        f.dx = ($urandom_range(0, 3) == 0) ? 12'sd0 : 12'($signed($urandom_range(0, 255)) - 128);
        f.dy = ($urandom_range(0, 3) == 0) ? 12'sd0 : 12'($signed($urandom_range(0, 255)) - 128);
        if ($urandom_range(0, 4) == 0)
            f.ft = 16'($urandom_range(0, 65535));
        else
            f.ft = 16'($urandom_range(500, 4000));
        f.flags = 6'($urandom_range(0, 63));
        return f;
    endfunction

    // Wait until the core has drained, then load the sensitivity
    task automatic set_sensitivity(input logic [15:0] v);
        wait (pending_frames.size() == 0 && expected_rows.size() == 0 && !in_valid);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        cam_sens = v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_frames.push_back(random_frame());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle frame, each move flag, cancelling and combined flags
        pending_frames.push_back(make_frame(0, 0, 0, 6'b000000));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b100000));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b010000));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b001000));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b000100));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b000010));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b000001));
        pending_frames.push_back(make_frame(0, 0, 65535, 6'b111111));
        pending_frames.push_back(make_frame(0, 0, 0, 6'b101010));
        pending_frames.push_back(make_frame(2047, 0, 65535, 6'b101010));
        pending_frames.push_back(make_frame(-2048, 0, 65535, 6'b000000));
        pending_frames.push_back(make_frame(0, 2047, 65535, 6'b000000));
        pending_frames.push_back(make_frame(0, -2048, 65535, 6'b010101));
        pending_frames.push_back(make_frame(1, -1, 1, 6'b000000));
        pending_frames.push_back(make_frame(-1, 1, 0, 6'b000000));
        queue_random(20);

        // Max sensitivity: pitch clamps at both ends, yaw wraps; long hold-off
        set_sensitivity(16'hFFFF);
        pending_frames.push_back(make_frame(0, 2047, 65535, 6'b001000));
        pending_frames.push_back(make_frame(0, -2048, 65535, 6'b001000));
        pending_frames.push_back(make_frame(2047, 0, 65535, 6'b100000));
        pending_frames.push_back(make_frame(2047, -2048, 65535, 6'b000000));
        hold_go = 1'b1;
        queue_random(40);
        wait (hold_left > 1);
        hold_go = 1'b0;

        set_sensitivity(16'h0000);
        queue_random(35);

        // Back-to-back stretch with no idling
        set_sensitivity(16'h0001);
        no_idle = 1'b1;
        queue_random(30);
        wait (pending_frames.size() == 0);
        no_idle = 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            set_sensitivity(16'($urandom_range(0, 65535)));
            queue_random(55);
        end
        set_sensitivity(16'd256);
        queue_random(N_ITEMS - 365);

        wait (pending_frames.size() == 0 && expected_rows.size() == 0 && !in_valid);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
